>>> rtl/soft_saturating_gain_limiter_macros.svh
// Assertion macros shared by the gain limiter RTL.
// No dependencies; included by the modules that carry checks.
`ifndef SOFT_SATURATING_GAIN_LIMITER_MACROS_SVH
`define SOFT_SATURATING_GAIN_LIMITER_MACROS_SVH

// Property must hold at every rising clock edge outside reset.
`define SSGL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition must never be seen outside reset.
`define SSGL_NEVER(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

>>> rtl/ssgl_pkg.sv
// Types, constants and register codes for the soft saturating gain limiter.
// No dependencies.
package ssgl_pkg;

   localparam int SAMPLE_WIDTH   = 16;
   localparam int SAMPLE_FRAC    = SAMPLE_WIDTH - 1;
   localparam int GAIN_WIDTH     = 16;
   localparam int GAIN_FRAC_BITS = 12;
   localparam int MAG_W          = SAMPLE_FRAC + 1;
   localparam int GV_W           = 2 * GAIN_WIDTH;
   localparam int PROD_W         = MAG_W + GV_W;
   localparam int SCALED_W       = PROD_W - 2 * GAIN_FRAC_BITS;
   localparam int NUM_W          = 2 * MAG_W + 2;
   localparam int DEN_W          = 2 * MAG_W + 1;
   localparam int DIV_STAGES     = SAMPLE_FRAC + 1;
   localparam int QUEUE_DEPTH    = 4;
   localparam int QPTR_W         = 2;
   localparam int QCNT_W         = 3;

   localparam logic [MAG_W-1:0] ONE = MAG_W'(1) << SAMPLE_FRAC;

   localparam logic [1:0] REG_MASTER_GAIN  = 2'd0;
   localparam logic [1:0] REG_LEFT_VOLUME  = 2'd1;
   localparam logic [1:0] REG_RIGHT_VOLUME = 2'd2;
   localparam logic [1:0] REG_SOFT_SAT_ON  = 2'd3;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_in;
      logic                           channel;
      logic                           block_end_in;
   } req_type;

   typedef struct packed {
      logic signed [SAMPLE_WIDTH-1:0] sample_out;
      logic                           clipped;
      logic                           block_end_out;
   } rsp_type;

   typedef struct packed {
      logic [GAIN_WIDTH-1:0] master_gain;
      logic [GAIN_WIDTH-1:0] left_volume;
      logic [GAIN_WIDTH-1:0] right_volume;
      logic                  soft_on;
   } cfg_type;

   // classified item between front and back
   typedef struct packed {
      logic             neg;
      logic             clip;
      logic             soft_en;
      logic             block_end;
      logic [MAG_W-1:0] mag;
   } item_type;

   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   typedef struct packed {
      item_type         item;
      logic [NUM_W-1:0] rem;
      logic [DEN_W-1:0] den;
      logic [MAG_W-1:0] quo;
   } div_type;

endpackage

>>> rtl/ssgl_front.sv
// Front end: accepts samples, applies gain and volume, classifies.
// Depends on ssgl_pkg and the assertion macros.
`include "soft_saturating_gain_limiter_macros.svh"

module ssgl_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_push,
   output logic                req_full,
   input  ssgl_pkg::req_type   req_data,
   input  ssgl_pkg::cfg_type   cfg,
   input  ssgl_pkg::qstat_type qstat,
   output logic                q_push,
   output ssgl_pkg::item_type  q_item
);

   logic                                 adv;
   logic                                 a_v_ff, b_v_ff, c_v_ff;
   logic                                 a_neg_ff, b_neg_ff, c_neg_ff;
   logic                                 a_be_ff, b_be_ff, c_be_ff;
   logic                                 a_ch_ff;
   logic [ssgl_pkg::MAG_W-1:0]           a_mag_ff, b_mag_ff;
   logic [ssgl_pkg::MAG_W-1:0]           mag_in;
   logic [ssgl_pkg::GV_W-1:0]            gv_ff;
   logic [ssgl_pkg::PROD_W-1:0]          p_ff;
   logic [ssgl_pkg::GAIN_WIDTH-1:0]      vol;
   logic [ssgl_pkg::SCALED_W-1:0]        scaled;
   logic                                 clip;

   assign adv      = !qstat.full;
   assign req_full = !adv;
   assign mag_in   = req_data.sample_in[ssgl_pkg::SAMPLE_WIDTH-1]
                   ? ssgl_pkg::MAG_W'(-req_data.sample_in)
                   : ssgl_pkg::MAG_W'(req_data.sample_in);
   assign vol      = a_ch_ff ? cfg.right_volume : cfg.left_volume;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_v_ff <= 1'b0;
         b_v_ff <= 1'b0;
         c_v_ff <= 1'b0;
      end else if (adv) begin
         a_v_ff <= req_push;
         b_v_ff <= a_v_ff;
         c_v_ff <= b_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_neg_ff <= req_data.sample_in[ssgl_pkg::SAMPLE_WIDTH-1];
         a_mag_ff <= mag_in;
         a_ch_ff  <= req_data.channel;
         a_be_ff  <= req_data.block_end_in;
         gv_ff    <= cfg.master_gain * vol;
         b_mag_ff <= a_mag_ff;
         b_neg_ff <= a_neg_ff;
         b_be_ff  <= a_be_ff;
         p_ff     <= ssgl_pkg::PROD_W'(b_mag_ff) * ssgl_pkg::PROD_W'(gv_ff);
         c_neg_ff <= b_neg_ff;
         c_be_ff  <= b_be_ff;
      end
   end

   assign scaled = p_ff[ssgl_pkg::PROD_W-1:2*ssgl_pkg::GAIN_FRAC_BITS];
   assign clip   = scaled > ssgl_pkg::SCALED_W'(ssgl_pkg::ONE);

   assign q_push         = c_v_ff && adv;
   assign q_item.neg       = c_neg_ff;
   assign q_item.clip      = clip;
   assign q_item.soft_en   = cfg.soft_on && !clip;
   assign q_item.block_end = c_be_ff;
   assign q_item.mag       = clip ? ssgl_pkg::ONE : scaled[ssgl_pkg::MAG_W-1:0];

   `SSGL_NEVER(a_front_push_full, clock, reset, q_push && qstat.full, "push into full queue")
   `SSGL_ASSERT(a_front_take, clock, reset, req_push && !req_full |=> a_v_ff, "lost transfer")
   `SSGL_ASSERT(a_front_hold, clock, reset, c_v_ff && !adv |=> c_v_ff, "stalled item dropped")

endmodule

>>> rtl/ssgl_queue.sv
// Short queue of classified items between front and back.
// Depends on ssgl_pkg and the assertion macros.
`include "soft_saturating_gain_limiter_macros.svh"

module ssgl_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ssgl_pkg::item_type  push_item,
   input  logic                pop,
   output ssgl_pkg::item_type  head,
   output ssgl_pkg::qstat_type stat
);

   ssgl_pkg::item_type              mem_ff [ssgl_pkg::QUEUE_DEPTH];
   logic [ssgl_pkg::QPTR_W-1:0]     wptr_ff, rptr_ff;
   logic [ssgl_pkg::QCNT_W-1:0]     cnt_ff;
   logic                            do_push, do_pop;

   function automatic logic [ssgl_pkg::QCNT_W-1:0] QCNT_inc(input logic b);
      return {{(ssgl_pkg::QCNT_W-1){1'b0}}, b};
   endfunction

   assign stat.full  = cnt_ff == ssgl_pkg::QCNT_W'(ssgl_pkg::QUEUE_DEPTH);
   assign stat.empty = cnt_ff == '0;
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && !stat.empty;
   assign head       = mem_ff[rptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         if (do_push) wptr_ff <= wptr_ff + 1'b1;
         if (do_pop)  rptr_ff <= rptr_ff + 1'b1;
         cnt_ff <= cnt_ff + QCNT_inc(do_push) - QCNT_inc(do_pop);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wptr_ff] <= push_item;
   end

   `SSGL_NEVER(a_q_over, clock, reset, cnt_ff > ssgl_pkg::QCNT_W'(ssgl_pkg::QUEUE_DEPTH), "overflow")
   `SSGL_NEVER(a_q_pop_empty, clock, reset, pop && stat.empty, "pop from empty queue")
   `SSGL_ASSERT(a_q_stay_full, clock, reset, stat.full && !pop |=> stat.full, "full lost")

endmodule

>>> rtl/ssgl_back.sv
// Back end: pipelined restoring divider for the soft curve, clamp, output register.
// Depends on ssgl_pkg and the assertion macros.
`include "soft_saturating_gain_limiter_macros.svh"

module ssgl_back (
   input  logic                clock,
   input  logic                reset,
   input  ssgl_pkg::item_type  q_head,
   input  ssgl_pkg::qstat_type qstat,
   output logic                q_pop,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output ssgl_pkg::rsp_type   rsp_data
);

   localparam int N = ssgl_pkg::DIV_STAGES;

   logic                     adv;
   logic [N:0]               v_ff;
   ssgl_pkg::div_type        st_ff [N+1];
   ssgl_pkg::div_type        st_in [N+1];
   logic                     out_v_ff;
   ssgl_pkg::rsp_type        out_ff;
   ssgl_pkg::div_type        last;
   logic [ssgl_pkg::MAG_W-1:0]   mag, m;
   logic [ssgl_pkg::MAG_W+2:0]   m_plus;
   logic                     quo_over;

   function automatic ssgl_pkg::rsp_type rsp_data_in(input ssgl_pkg::div_type d);
      ssgl_pkg::rsp_type            r;
      logic [ssgl_pkg::MAG_W-1:0]   mg;
      mg = (d.quo >= ssgl_pkg::ONE) ? ssgl_pkg::ONE : d.quo;
      if (d.item.neg)
         r.sample_out = ssgl_pkg::SAMPLE_WIDTH'(-mg);
      else if (mg >= ssgl_pkg::ONE)
         r.sample_out = ssgl_pkg::SAMPLE_WIDTH'(ssgl_pkg::ONE - 1'b1);
      else
         r.sample_out = ssgl_pkg::SAMPLE_WIDTH'(mg);
      r.clipped       = d.item.clip;
      r.block_end_out = d.item.block_end;
      return r;
   endfunction

   assign adv   = !out_v_ff || rsp_pop;
   assign q_pop = adv && !qstat.empty;

   assign m      = q_head.mag;
   assign m_plus = (ssgl_pkg::MAG_W+3)'(m) + (ssgl_pkg::MAG_W+3)'(5) * (ssgl_pkg::MAG_W+3)'(ssgl_pkg::ONE);

   always_comb begin
      st_in[0].item = q_head;
      st_in[0].rem  = ssgl_pkg::NUM_W'(ssgl_pkg::NUM_W'(m) * ssgl_pkg::NUM_W'(m_plus));
      st_in[0].den  = ssgl_pkg::DEN_W'(m) * ssgl_pkg::DEN_W'(m)
                    + (ssgl_pkg::DEN_W'(m) << (ssgl_pkg::SAMPLE_FRAC + 2))
                    + (ssgl_pkg::DEN_W'(1) << (2 * ssgl_pkg::SAMPLE_FRAC));
      st_in[0].quo  = q_head.soft_en ? '0 : m;
      for (int k = 0; k < N; k++) begin
         logic [ssgl_pkg::NUM_W-1:0] r;
         r = (k == 0) ? st_ff[k].rem : (st_ff[k].rem << 1);
         st_in[k+1] = st_ff[k];
         if (st_ff[k].item.soft_en) begin
            if (r >= ssgl_pkg::NUM_W'(st_ff[k].den)) begin
               st_in[k+1].rem = r - ssgl_pkg::NUM_W'(st_ff[k].den);
               st_in[k+1].quo = {st_ff[k].quo[ssgl_pkg::MAG_W-2:0], 1'b1};
            end else begin
               st_in[k+1].rem = r;
               st_in[k+1].quo = {st_ff[k].quo[ssgl_pkg::MAG_W-2:0], 1'b0};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff     <= '0;
         out_v_ff <= 1'b0;
      end else if (adv) begin
         v_ff     <= {v_ff[N-1:0], !qstat.empty};
         out_v_ff <= v_ff[N];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k <= N; k++) st_ff[k] <= st_in[k];
         out_ff <= rsp_data_in(st_ff[N]);
      end
   end

   assign last     = st_ff[N];
   assign mag      = (last.quo >= ssgl_pkg::ONE) ? ssgl_pkg::ONE : last.quo;
   assign quo_over = last.item.soft_en && last.quo > ssgl_pkg::ONE;

   assign rsp_empty = !out_v_ff;
   assign rsp_data  = out_ff;

   `SSGL_NEVER(a_back_quo, clock, reset, v_ff[N] && quo_over, "soft curve above one")
   `SSGL_NEVER(a_back_clamp, clock, reset, v_ff[N] && mag > ssgl_pkg::ONE, "clamp failed")
   `SSGL_ASSERT(a_back_hold, clock, reset, out_v_ff && !rsp_pop |=> out_v_ff && $stable(out_ff), "result overwritten")

endmodule

>>> rtl/soft_saturating_gain_limiter.sv
// Soft saturating gain limiter, top level: register file, front, queue, back.
// Depends on ssgl_pkg, ssgl_front, ssgl_queue, ssgl_back.
//
// Takes one Q1.15 sample per clock when rsp_pop keeps up: scaling by master
// gain and channel volume in three front stages, a four-entry queue, then a
// 16-stage restoring divider for the soft curve and an output register.
// Throughput is one sample per cycle; a result held by a low rsp_pop stalls
// the back end, the queue then fills and req_full rises. Write the csr
// registers only while nothing is in flight.
module soft_saturating_gain_limiter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  ssgl_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output ssgl_pkg::rsp_type rsp_data,
   input  logic              csr_we,
   input  logic [1:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   ssgl_pkg::cfg_type   cfg_ff;
   ssgl_pkg::qstat_type qstat;
   ssgl_pkg::item_type  q_item, q_head;
   logic                q_push, q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_gain  <= 16'd4096;
         cfg_ff.left_volume  <= 16'd4096;
         cfg_ff.right_volume <= 16'd4096;
         cfg_ff.soft_on      <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            ssgl_pkg::REG_MASTER_GAIN:  cfg_ff.master_gain  <= csr_wdata;
            ssgl_pkg::REG_LEFT_VOLUME:  cfg_ff.left_volume  <= csr_wdata;
            ssgl_pkg::REG_RIGHT_VOLUME: cfg_ff.right_volume <= csr_wdata;
            ssgl_pkg::REG_SOFT_SAT_ON:  cfg_ff.soft_on      <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   ssgl_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .cfg      (cfg_ff),
      .qstat    (qstat),
      .q_push   (q_push),
      .q_item   (q_item)
   );

   ssgl_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (q_item),
      .pop       (q_pop),
      .head      (q_head),
      .stat      (qstat)
   );

   ssgl_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_head    (q_head),
      .qstat     (qstat),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/tb_soft_saturating_gain_limiter.sv
// Self-checking testbench for soft_saturating_gain_limiter: directed table then random
// samples, checked against fixed table results or a behavioral gain/soft-clip predictor.
// Depends on ssgl_pkg and the soft_saturating_gain_limiter RTL.
`timescale 1ns / 100ps
module tb_soft_saturating_gain_limiter;

   logic clock = 0;
   logic reset = 1;
   logic req_push = 0;
   logic req_full;
   ssgl_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 0;
   ssgl_pkg::rsp_type rsp_data;
   logic csr_we = 0;
   logic [1:0] csr_index = ssgl_pkg::REG_MASTER_GAIN;
   logic [15:0] csr_wdata = '0;

   soft_saturating_gain_limiter uut (.*);

   always #4 clock = ~clock;

   typedef struct {
      logic signed [15:0] sample;
      logic chan;
      logic bend;
      logic known;
      ssgl_pkg::rsp_type want;
   } row_type;

   logic [15:0] gain_reg, lvol_reg, rvol_reg;
   logic soft_reg;
   ssgl_pkg::rsp_type expected_q[$];
   int errors = 0;
   int hold_off = 0;
   int rx_wait = 0;
   bit stim_done = 0;

   function automatic logic [63:0] soft_curve(logic [63:0] m);
      logic [63:0] s, num, den, q, r;
      s = 64'd1 << ssgl_pkg::SAMPLE_FRAC;
      num = m * (m + 5 * s);
      den = m * m + 4 * m * s + s * s;
      q = 0;
      r = num;
      if (r >= den) begin
         q = 1;
         r -= den;
      end
      for (int i = 0; i < ssgl_pkg::SAMPLE_FRAC; i++) begin
         r = r << 1;
         q = q << 1;
         if (r >= den) begin
            r -= den;
            q |= 1;
         end
      end
      return q;
   endfunction

   function automatic ssgl_pkg::rsp_type limit_sample(ssgl_pkg::req_type d);
      logic [63:0] one, mag, m, vol;
      logic neg, clip;
      ssgl_pkg::rsp_type o;
      one = 64'd1 << ssgl_pkg::SAMPLE_FRAC;
      neg = d.sample_in[15];
      mag = neg ? (64'd65536 - {48'd0, d.sample_in}) : {48'd0, d.sample_in};
      vol = d.channel ? rvol_reg : lvol_reg;
      m = (mag * (gain_reg * vol)) >> (2 * ssgl_pkg::GAIN_FRAC_BITS);
      clip = 0;
      if (m > one) begin
         clip = 1;
         m = one;
      end else if (soft_reg) begin
         m = soft_curve(m);
         if (m > one) m = one;
      end
      if (neg) o.sample_out = 16'(64'd65536 - m);
      else o.sample_out = (m >= one) ? 16'h7fff : 16'(m);
      o.clipped = clip;
      o.block_end_out = d.block_end_in;
      return o;
   endfunction

   task automatic write_reg(logic [1:0] idx, logic [15:0] val);
      @(posedge clock);
      csr_we <= 1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         ssgl_pkg::REG_MASTER_GAIN: gain_reg = val;
         ssgl_pkg::REG_LEFT_VOLUME: lvol_reg = val;
         ssgl_pkg::REG_RIGHT_VOLUME: rvol_reg = val;
         ssgl_pkg::REG_SOFT_SAT_ON: soft_reg = val[0];
         default: ;
      endcase
   endtask

   task automatic drain();
      req_push <= 0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (30) @(posedge clock);
   endtask

   task automatic send_sample(ssgl_pkg::req_type d, logic known, ssgl_pkg::rsp_type want);
      int gap;
      ssgl_pkg::rsp_type exp_rsp;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1;
      req_data <= d;
      do @(posedge clock); while (req_full);
      exp_rsp = known ? want : limit_sample(d);
      expected_q = {expected_q, exp_rsp};
   endtask

   task automatic random_phase(int n, int wide);
      ssgl_pkg::req_type d;
      for (int i = 0; i < n; i++) begin
         d.sample_in = 16'($urandom);
         if (!wide && $urandom_range(0, 1)) d.sample_in = $signed(d.sample_in) >>> 3;
         d.channel = 1'($urandom_range(0, 1));
         d.block_end_in = 1'($urandom_range(0, 1));
         send_sample(d, 0, '0);
      end
   endtask

   initial begin
      row_type dir[$];
      ssgl_pkg::req_type d;
      gain_reg = 4096;
      lvol_reg = 4096;
      rvol_reg = 4096;
      soft_reg = 0;
      repeat (4) @(posedge clock);
      reset <= 0;
      dir = '{
         '{16'sd0, 0, 0, 1, '{16'sd0, 0, 0}},
         '{16'sd32767, 0, 1, 1, '{16'sd32767, 0, 1}},
         '{-16'sd32768, 1, 0, 1, '{-16'sd32768, 0, 0}},
         '{16'sd1, 1, 1, 1, '{16'sd1, 0, 1}},
         '{-16'sd1, 0, 0, 1, '{-16'sd1, 0, 0}},
         '{16'sd12345, 1, 0, 0, '{16'sd0, 0, 0}},
         '{-16'sd20000, 0, 1, 0, '{16'sd0, 0, 0}}
      };
      foreach (dir[i]) begin
         d = '{dir[i].sample, dir[i].chan, dir[i].bend};
         send_sample(d, dir[i].known, dir[i].want);
      end
      drain();
      write_reg(ssgl_pkg::REG_MASTER_GAIN, 16'd8192);
      foreach (dir[i]) begin
         d = '{dir[i].sample, dir[i].chan, dir[i].bend};
         send_sample(d, 0, '0);
      end
      drain();
      write_reg(ssgl_pkg::REG_SOFT_SAT_ON, 16'd1);
      write_reg(ssgl_pkg::REG_MASTER_GAIN, 16'd4096);
      foreach (dir[i]) begin
         d = '{dir[i].sample, dir[i].chan, dir[i].bend};
         send_sample(d, 0, '0);
      end
      hold_off = 300;
      random_phase(30, 1);
      drain();
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               write_reg(ssgl_pkg::REG_MASTER_GAIN, 16'hffff);
               write_reg(ssgl_pkg::REG_LEFT_VOLUME, 16'hffff);
               write_reg(ssgl_pkg::REG_RIGHT_VOLUME, 16'd0);
               write_reg(ssgl_pkg::REG_SOFT_SAT_ON, 16'd0);
            end
            1: begin
               write_reg(ssgl_pkg::REG_MASTER_GAIN, 16'd0);
               write_reg(ssgl_pkg::REG_SOFT_SAT_ON, 16'd1);
            end
            default: begin
               write_reg(ssgl_pkg::REG_MASTER_GAIN, 16'($urandom_range(0, 12000)));
               write_reg(ssgl_pkg::REG_LEFT_VOLUME, 16'($urandom));
               write_reg(ssgl_pkg::REG_RIGHT_VOLUME, 16'($urandom_range(0, 8192)));
               write_reg(ssgl_pkg::REG_SOFT_SAT_ON, 16'($urandom_range(0, 1)));
            end
         endcase
         random_phase(100, ph & 1);
         drain();
      end
      stim_done = 1;
   end

   always @(posedge clock) begin
      int w;
      if (hold_off > 0) begin
         hold_off <= hold_off - 1;
         rsp_pop <= 1'b0;
      end else if (rx_wait > 0) begin
         rx_wait <= rx_wait - 1;
         rsp_pop <= (rx_wait == 1);
      end else if (rsp_pop && !rsp_empty) begin
         w = $urandom_range(0, 8);
         rsp_pop <= (w == 0);
         rx_wait <= w;
      end else begin
         rsp_pop <= 1'b1;
      end
   end

   always @(posedge clock) begin
      ssgl_pkg::rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_q.size() == 0) begin
            $display("%0t: unexpected transfer, actual %h", $time, rsp_data);
            errors++;
         end else begin
            want = expected_q.pop_front();
            if (rsp_data.sample_out !== want.sample_out) begin
               $display("%0t: sample_out expected %0d actual %0d", $time,
                        want.sample_out, rsp_data.sample_out);
               errors++;
            end
            if (rsp_data.clipped !== want.clipped) begin
               $display("%0t: clipped expected %b actual %b", $time,
                        want.clipped, rsp_data.clipped);
               errors++;
            end
            if (rsp_data.block_end_out !== want.block_end_out) begin
               $display("%0t: block_end_out expected %b actual %b", $time,
                        want.block_end_out, rsp_data.block_end_out);
               errors++;
            end
         end
      end
   end

   initial begin
      wait (stim_done);
      repeat (40) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("tb_soft_saturating_gain_limiter passed");
      end else begin
         $display("tb_soft_saturating_gain_limiter failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("tb_soft_saturating_gain_limiter failed");
      $finish;
   end
endmodule

>>> filelist.f
+incdir+rtl
rtl/ssgl_pkg.sv
rtl/ssgl_front.sv
rtl/ssgl_queue.sv
rtl/ssgl_back.sv
rtl/soft_saturating_gain_limiter.sv
tb/tb_soft_saturating_gain_limiter.sv
